// File: rtl/ebgd_pkg.sv
// ----------------------------------------------------------------------------
// ebgd_pkg
// types and constants shared by the encoder button gesture detector
// ----------------------------------------------------------------------------
package ebgd_pkg;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_CONSUME = 1'b1;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ULTRA_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_TMO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN   = 2'd3;

    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [15:0] ULTRA_LONG_RST = 16'd3000;
    localparam logic [15:0] CLICK_TMO_RST  = 16'd500;
    localparam logic [15:0] DOUBLE_WIN_RST = 16'd300;

    localparam int MASK_MOVE     = 0;
    localparam int MASK_ROTATE   = 1;
    localparam int MASK_CLICK    = 2;
    localparam int MASK_DOUBLE   = 3;
    localparam int MASK_LONG     = 4;
    localparam int MASK_ULTRA    = 5;
    localparam int MASK_GESTURE  = 6;
    localparam int MASK_DURATION = 7;

    localparam logic signed [15:0] MOVE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] MOVE_MIN = -16'sh8000;

    typedef struct packed {
        logic              cmd;
        logic              switch_level;
        logic signed [15:0] encoder_count;
        logic [31:0]       now_ms;
        logic [7:0]        take_mask;
    } item_t;

    typedef struct packed {
        logic signed [15:0] movement_out;
        logic signed [15:0] rotate_movement_out;
        logic              click_flag;
        logic              double_click_flag;
        logic              long_press_flag;
        logic              ultra_long_flag;
        logic              press_rotate_flag;
        logic              button_down;
        logic              long_reached;
        logic [31:0]       press_time_ms;
        logic [31:0]       last_press_ms;
    } result_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] ultra_long_press_ms;
        logic [15:0] click_timeout_ms;
        logic [15:0] double_click_window_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [13:0] last_detent;
        logic signed [15:0] movement_total;
        logic              movement_waiting;
        logic              gesture_active;
        logic              gesture_waiting;
        logic              click_waiting;
        logic              double_waiting;
        logic              long_waiting;
        logic              ultra_waiting;
        logic              ultra_announced;
        logic              awaiting_second_click;
        logic              long_threshold_seen;
        logic              previous_level;
        logic [31:0]       press_start_time;
        logic [31:0]       first_click_time;
        logic [31:0]       last_duration;
    } state_t;

endpackage

// File: rtl/ebgd_ifs.sv
// ----------------------------------------------------------------------------
// ebgd channel interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface ebgd_item_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic              switch_level;
    logic signed [15:0] encoder_count;
    logic [31:0]       now_ms;
    logic [7:0]        take_mask;

    modport source (output valid, cmd, switch_level, encoder_count, now_ms, take_mask,
                    input ready);
    modport sink   (input valid, cmd, switch_level, encoder_count, now_ms, take_mask,
                    output ready);
endinterface

interface ebgd_result_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] movement_out;
    logic signed [15:0] rotate_movement_out;
    logic              click_flag;
    logic              double_click_flag;
    logic              long_press_flag;
    logic              ultra_long_flag;
    logic              press_rotate_flag;
    logic              button_down;
    logic              long_reached;
    logic [31:0]       press_time_ms;
    logic [31:0]       last_press_ms;

    modport source (output valid, movement_out, rotate_movement_out, click_flag,
                    double_click_flag, long_press_flag, ultra_long_flag,
                    press_rotate_flag, button_down, long_reached, press_time_ms,
                    last_press_ms,
                    input ready);
    modport sink   (input valid, movement_out, rotate_movement_out, click_flag,
                    double_click_flag, long_press_flag, ultra_long_flag,
                    press_rotate_flag, button_down, long_reached, press_time_ms,
                    last_press_ms,
                    output ready);
endinterface

interface ebgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ebgd_core.sv
// ----------------------------------------------------------------------------
// ebgd_core
// gesture and movement state with its single-pass update per item
// ----------------------------------------------------------------------------
module ebgd_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ebgd_pkg::item_t  item,
    input  ebgd_pkg::cfg_t   cfg,
    output ebgd_pkg::result_t result
);
    import ebgd_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic signed [15:0] cnt_adj;
    logic signed [13:0] detent;

    // all clear, switch seen as released
    function automatic state_t reset_state();
        state_t rs;
        rs                = '0;
        rs.previous_level = LEVEL_RELEASED;
        return rs;
    endfunction

    assign cnt_adj = item.encoder_count[15] ? item.encoder_count + 16'sd3
                                            : item.encoder_count;
    assign detent  = cnt_adj[15:2];

    always_comb
    begin
        state_t             s;
        logic               down;
        logic               edge_seen;
        logic signed [16:0] sum;
        logic [31:0]        dur;
        logic [31:0]        held;
        logic               take_norm;
        logic               take_rot;

        s           = state_reg;
        down        = (item.switch_level == LEVEL_PRESSED);
        sum         = '0;
        dur         = '0;
        held        = '0;
        edge_seen   = 1'b0;
        result      = '0;

        if (item.cmd == CMD_SAMPLE)
        begin
            // encoder first
            if (detent != s.last_detent)
            begin
                sum = 17'(s.movement_total) + 17'(detent) - 17'(s.last_detent);
                if (sum[16] != sum[15])
                    s.movement_total = sum[16] ? MOVE_MIN : MOVE_MAX;
                else
                    s.movement_total = sum[15:0];
                s.last_detent      = detent;
                s.movement_waiting = 1'b1;
                if (down && !s.gesture_active)
                begin
                    s.gesture_waiting       = 1'b1;
                    s.gesture_active        = 1'b1;
                    s.click_waiting         = 1'b0;
                    s.long_waiting          = 1'b0;
                    s.ultra_waiting         = 1'b0;
                    s.awaiting_second_click = 1'b0;
                    s.long_threshold_seen   = 1'b0;
                    s.ultra_announced       = 1'b0;
                end
            end

            // button
            edge_seen = (item.switch_level != s.previous_level);
            if (edge_seen && item.switch_level == LEVEL_PRESSED)
            begin
                s.press_start_time    = item.now_ms;
                s.long_threshold_seen = 1'b0;
                s.ultra_announced     = 1'b0;
                s.gesture_active      = 1'b0;
            end
            if (edge_seen && item.switch_level == LEVEL_RELEASED)
            begin
                dur             = item.now_ms - s.press_start_time;
                s.last_duration = dur;
                priority if (s.gesture_active)
                    s.gesture_active = 1'b0;
                else if (dur >= 32'(cfg.ultra_long_press_ms))
                begin
                    if (!s.ultra_announced)
                    begin
                        s.ultra_waiting   = 1'b1;
                        s.ultra_announced = 1'b1;
                    end
                end
                else if (dur >= 32'(cfg.long_press_ms))
                    s.long_waiting = 1'b1;
                else if (dur < 32'(cfg.click_timeout_ms))
                begin
                    if (s.awaiting_second_click)
                    begin
                        s.double_waiting        = 1'b1;
                        s.awaiting_second_click = 1'b0;
                        s.click_waiting         = 1'b0;
                    end
                    else
                    begin
                        s.awaiting_second_click = 1'b1;
                        s.first_click_time      = item.now_ms;
                    end
                end
                else
                begin
                    // between click timeout and long press: no event
                end
            end

            if (down && !s.gesture_active)
            begin
                held = item.now_ms - s.press_start_time;
                if (held >= 32'(cfg.long_press_ms))
                    s.long_threshold_seen = 1'b1;
                if (held >= 32'(cfg.ultra_long_press_ms) && !s.ultra_announced)
                begin
                    s.ultra_waiting   = 1'b1;
                    s.ultra_announced = 1'b1;
                end
            end
            else if (s.ultra_announced && s.last_duration < 32'(cfg.ultra_long_press_ms))
                s.ultra_announced = 1'b0;

            if (s.awaiting_second_click &&
                (item.now_ms - s.first_click_time) > 32'(cfg.double_click_window_ms))
            begin
                s.click_waiting         = 1'b1;
                s.awaiting_second_click = 1'b0;
            end

            s.previous_level = item.switch_level;
        end

        result.click_flag        = s.click_waiting;
        result.double_click_flag = s.double_waiting;
        result.long_press_flag   = s.long_waiting;
        result.ultra_long_flag   = s.ultra_waiting;
        result.press_rotate_flag = s.gesture_waiting;
        result.last_press_ms     = s.last_duration;
        result.button_down       = down;
        result.long_reached      = s.long_threshold_seen && down;
        result.press_time_ms     = down ? item.now_ms - s.press_start_time : '0;

        take_norm = !down && !s.gesture_active && s.movement_waiting;
        take_rot  = s.gesture_active && s.movement_waiting;

        if (item.cmd == CMD_CONSUME)
        begin
            if (take_norm)
                result.movement_out = s.movement_total;
            if (take_rot)
                result.rotate_movement_out = s.movement_total;
            if ((item.take_mask[MASK_MOVE] && take_norm) ||
                (item.take_mask[MASK_ROTATE] && take_rot))
            begin
                s.movement_total   = '0;
                s.movement_waiting = 1'b0;
            end
            if (item.take_mask[MASK_CLICK])
                s.click_waiting = 1'b0;
            if (item.take_mask[MASK_DOUBLE])
                s.double_waiting = 1'b0;
            if (item.take_mask[MASK_LONG])
                s.long_waiting = 1'b0;
            if (item.take_mask[MASK_ULTRA])
                s.ultra_waiting = 1'b0;
            if (item.take_mask[MASK_GESTURE])
                s.gesture_waiting = 1'b0;
            if (item.take_mask[MASK_DURATION])
                s.last_duration = '0;
        end

        state_next = step ? s : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reset_state();
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/encoder_button_gesture_detector.sv
// ----------------------------------------------------------------------------
// encoder_button_gesture_detector
// rotary movement totals and push-button gesture sorting, one result per item
//
//   channel | role   | transfer
//   --------+--------+-------------------------------------------------
//   item    | sink   | command, switch level, encoder count, time, mask
//   result  | source | movement, rotate movement, event flags, times
//   cfg     | sink   | register index and 16-bit value
//
// one item per cycle sustained while results are taken; an item is held in the input register
// and is updated against the state on its way into the result register
// result valid once the updated item is loaded into the result register
// reset clears the state and loads the default thresholds; no clearing pass
// a stalled result holds the result register, the input register still
// takes one more item; register writes are always accepted
// ----------------------------------------------------------------------------
module encoder_button_gesture_detector
(
    input  logic          clk,
    input  logic          rst_n,
    ebgd_item_if.sink     item,
    ebgd_result_if.source result,
    ebgd_cfg_if.sink      cfg
);
    import ebgd_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    cfg_t    cfg_reg;
    result_t core_result;
    item_t   item_data;
    logic    advance;
    logic    step;

    assign advance    = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign item_data.cmd           = item.cmd;
    assign item_data.switch_level  = item.switch_level;
    assign item_data.encoder_count = item.encoder_count;
    assign item_data.now_ms        = item.now_ms;
    assign item_data.take_mask     = item.take_mask;

    ebgd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_item_reg <= item_data;
        if (step)
            out_data_reg <= core_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms          <= LONG_PRESS_RST;
            cfg_reg.ultra_long_press_ms    <= ULTRA_LONG_RST;
            cfg_reg.click_timeout_ms       <= CLICK_TMO_RST;
            cfg_reg.double_click_window_ms <= DOUBLE_WIN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_LONG_PRESS: cfg_reg.long_press_ms          <= cfg.data;
                REG_ULTRA_LONG: cfg_reg.ultra_long_press_ms    <= cfg.data;
                REG_CLICK_TMO:  cfg_reg.click_timeout_ms       <= cfg.data;
                REG_DOUBLE_WIN: cfg_reg.double_click_window_ms <= cfg.data;
                default:        cfg_reg                        <= cfg_reg;
            endcase
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.movement_out        = out_data_reg.movement_out;
    assign result.rotate_movement_out = out_data_reg.rotate_movement_out;
    assign result.click_flag          = out_data_reg.click_flag;
    assign result.double_click_flag   = out_data_reg.double_click_flag;
    assign result.long_press_flag     = out_data_reg.long_press_flag;
    assign result.ultra_long_flag     = out_data_reg.ultra_long_flag;
    assign result.press_rotate_flag   = out_data_reg.press_rotate_flag;
    assign result.button_down         = out_data_reg.button_down;
    assign result.long_reached        = out_data_reg.long_reached;
    assign result.press_time_ms       = out_data_reg.press_time_ms;
    assign result.last_press_ms       = out_data_reg.last_press_ms;

endmodule

// File: bench/ebgd_checker.sv
// ----------------------------------------------------------------------------
// ebgd_checker
// watches the item, result and register channels of the gesture detector,
// keeps its own copy of the thresholds and the tracking state, predicts one
// result per accepted item and compares every returned result field by field
// ----------------------------------------------------------------------------
module ebgd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    ebgd_item_if        item,
    ebgd_result_if      result,
    ebgd_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned pending
);
    import ebgd_pkg::*;

    localparam int DETENT_STEP = 4;
    localparam int MAX_REPORTS = 10;

    cfg_t        thresholds;
    state_t      tracked;
    result_t     predicted_results[$];
    int unsigned n_fail = 0;
    int unsigned n_pending = 0;
    int unsigned results_seen = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    task automatic note_failure(input string what);
        if (n_fail < MAX_REPORTS)
            $display("result %0d: %s", results_seen, what);
        n_fail++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected 'h%0h actual 'h%0h", name, want, got));
    endtask

    // one item against the tracked state; encoder first, then the switch
    task automatic predict_gesture_step(input item_t it, output result_t r);
        logic        down;
        logic        level_edge;
        int          det;
        int          prev_det;
        int          sum;
        logic [31:0] dur;
        logic [31:0] held;
        logic        take_norm;
        logic        take_rot;
        down = (it.switch_level == LEVEL_PRESSED);
        r = '0;
        if (it.cmd == CMD_SAMPLE)
        begin
            det = $signed(it.encoder_count);
            det = det / DETENT_STEP;
            prev_det = tracked.last_detent;
            if (det != prev_det)
            begin
                sum = int'(tracked.movement_total) + det - prev_det;
                if (sum > int'(MOVE_MAX))
                    sum = int'(MOVE_MAX);
                if (sum < int'(MOVE_MIN))
                    sum = int'(MOVE_MIN);
                tracked.movement_total   = sum[15:0];
                tracked.last_detent      = det[13:0];
                tracked.movement_waiting = 1'b1;
                if (down && !tracked.gesture_active)
                begin
                    tracked.gesture_waiting       = 1'b1;
                    tracked.gesture_active        = 1'b1;
                    tracked.click_waiting         = 1'b0;
                    tracked.long_waiting          = 1'b0;
                    tracked.ultra_waiting         = 1'b0;
                    tracked.awaiting_second_click = 1'b0;
                    tracked.long_threshold_seen   = 1'b0;
                    tracked.ultra_announced       = 1'b0;
                end
            end

            level_edge = (it.switch_level != tracked.previous_level);
            if (level_edge && it.switch_level == LEVEL_PRESSED)
            begin
                tracked.press_start_time    = it.now_ms;
                tracked.long_threshold_seen = 1'b0;
                tracked.ultra_announced     = 1'b0;
                tracked.gesture_active      = 1'b0;
            end
            if (level_edge && it.switch_level == LEVEL_RELEASED)
            begin
                dur = it.now_ms - tracked.press_start_time;
                tracked.last_duration = dur;
                if (tracked.gesture_active)
                    tracked.gesture_active = 1'b0;
                else if (dur >= thresholds.ultra_long_press_ms)
                begin
                    if (!tracked.ultra_announced)
                    begin
                        tracked.ultra_waiting   = 1'b1;
                        tracked.ultra_announced = 1'b1;
                    end
                end
                else if (dur >= thresholds.long_press_ms)
                    tracked.long_waiting = 1'b1;
                else if (dur < thresholds.click_timeout_ms)
                begin
                    if (tracked.awaiting_second_click)
                    begin
                        tracked.double_waiting        = 1'b1;
                        tracked.awaiting_second_click = 1'b0;
                        tracked.click_waiting         = 1'b0;
                    end
                    else
                    begin
                        tracked.awaiting_second_click = 1'b1;
                        tracked.first_click_time      = it.now_ms;
                    end
                end
            end
            if (down && !tracked.gesture_active)
            begin
                held = it.now_ms - tracked.press_start_time;
                if (held >= thresholds.long_press_ms)
                    tracked.long_threshold_seen = 1'b1;
                if (held >= thresholds.ultra_long_press_ms && !tracked.ultra_announced)
                begin
                    tracked.ultra_waiting   = 1'b1;
                    tracked.ultra_announced = 1'b1;
                end
            end
            else if (tracked.ultra_announced &&
                     tracked.last_duration < thresholds.ultra_long_press_ms)
                tracked.ultra_announced = 1'b0;
            if (tracked.awaiting_second_click &&
                (it.now_ms - tracked.first_click_time) > thresholds.double_click_window_ms)
            begin
                tracked.click_waiting         = 1'b1;
                tracked.awaiting_second_click = 1'b0;
            end
            tracked.previous_level = it.switch_level;
        end

        r.click_flag        = tracked.click_waiting;
        r.double_click_flag = tracked.double_waiting;
        r.long_press_flag   = tracked.long_waiting;
        r.ultra_long_flag   = tracked.ultra_waiting;
        r.press_rotate_flag = tracked.gesture_waiting;
        r.last_press_ms     = tracked.last_duration;

        if (it.cmd == CMD_CONSUME)
        begin
            take_norm = !down && !tracked.gesture_active && tracked.movement_waiting;
            take_rot  = tracked.gesture_active && tracked.movement_waiting;
            if (take_norm)
                r.movement_out = tracked.movement_total;
            if (take_rot)
                r.rotate_movement_out = tracked.movement_total;
            if ((it.take_mask[MASK_MOVE] && take_norm) ||
                (it.take_mask[MASK_ROTATE] && take_rot))
            begin
                tracked.movement_total   = '0;
                tracked.movement_waiting = 1'b0;
            end
            if (it.take_mask[MASK_CLICK])
                tracked.click_waiting = 1'b0;
            if (it.take_mask[MASK_DOUBLE])
                tracked.double_waiting = 1'b0;
            if (it.take_mask[MASK_LONG])
                tracked.long_waiting = 1'b0;
            if (it.take_mask[MASK_ULTRA])
                tracked.ultra_waiting = 1'b0;
            if (it.take_mask[MASK_GESTURE])
                tracked.gesture_waiting = 1'b0;
            if (it.take_mask[MASK_DURATION])
                tracked.last_duration = '0;
        end

        r.button_down   = down;
        r.long_reached  = tracked.long_threshold_seen && down;
        r.press_time_ms = down ? it.now_ms - tracked.press_start_time : 32'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   accepted;
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            tracked = '0;
            tracked.previous_level = LEVEL_RELEASED;
            thresholds.long_press_ms          = LONG_PRESS_RST;
            thresholds.ultra_long_press_ms    = ULTRA_LONG_RST;
            thresholds.click_timeout_ms       = CLICK_TMO_RST;
            thresholds.double_click_window_ms = DOUBLE_WIN_RST;
            predicted_results.delete();
            n_pending <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.movement_out        = result.movement_out;
                got.rotate_movement_out = result.rotate_movement_out;
                got.click_flag          = result.click_flag;
                got.double_click_flag   = result.double_click_flag;
                got.long_press_flag     = result.long_press_flag;
                got.ultra_long_flag     = result.ultra_long_flag;
                got.press_rotate_flag   = result.press_rotate_flag;
                got.button_down         = result.button_down;
                got.long_reached        = result.long_reached;
                got.press_time_ms       = result.press_time_ms;
                got.last_press_ms       = result.last_press_ms;
                if (predicted_results.size() == 0)
                    note_failure("result transfer with no prediction waiting");
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("movement_out", want.movement_out, got.movement_out);
                    check_field("rotate_movement_out", want.rotate_movement_out,
                                got.rotate_movement_out);
                    check_field("click_flag", want.click_flag, got.click_flag);
                    check_field("double_click_flag", want.double_click_flag,
                                got.double_click_flag);
                    check_field("long_press_flag", want.long_press_flag,
                                got.long_press_flag);
                    check_field("ultra_long_flag", want.ultra_long_flag,
                                got.ultra_long_flag);
                    check_field("press_rotate_flag", want.press_rotate_flag,
                                got.press_rotate_flag);
                    check_field("button_down", want.button_down, got.button_down);
                    check_field("long_reached", want.long_reached, got.long_reached);
                    check_field("press_time_ms", want.press_time_ms, got.press_time_ms);
                    check_field("last_press_ms", want.last_press_ms, got.last_press_ms);
                end
                results_seen++;
            end

            if (item.valid && item.ready)
            begin
                accepted.cmd           = item.cmd;
                accepted.switch_level  = item.switch_level;
                accepted.encoder_count = item.encoder_count;
                accepted.now_ms        = item.now_ms;
                accepted.take_mask     = item.take_mask;
                predict_gesture_step(accepted, want);
                predicted_results.push_back(want);
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LONG_PRESS: thresholds.long_press_ms          = cfg.data;
                    REG_ULTRA_LONG: thresholds.ultra_long_press_ms    = cfg.data;
                    REG_CLICK_TMO:  thresholds.click_timeout_ms       = cfg.data;
                    REG_DOUBLE_WIN: thresholds.double_click_window_ms = cfg.data;
                    default: ;
                endcase
            end

            n_pending <= predicted_results.size();
        end
    end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the encoder button gesture detector: directed corner items at
// the default thresholds, then click, double click, long, ultra-long and
// press-and-rotate sequences with random timing, consumes and noise over
// several threshold settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
    import ebgd_pkg::*;

    localparam int PHASE_ITEMS = 100;
    localparam int N_PHASES    = 6;
    localparam int DRAIN_SLACK = 4;
    localparam int TIMEOUT     = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ebgd_item_if   item_ch();
    ebgd_result_if result_ch();
    ebgd_cfg_if    cfg_ch();

    int unsigned fail_count;
    int unsigned pending;

    cfg_t                thr_now;
    logic [31:0]         clock_ms = '0;
    logic signed [15:0]  enc_pos  = '0;
    logic                level_now = LEVEL_RELEASED;
    int unsigned         sent = 0;
    bit                  steady = 1'b0;

    always #2 clk = ~clk;

    encoder_button_gesture_detector u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ebgd_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= it.cmd;
        item_ch.switch_level  <= it.switch_level;
        item_ch.encoder_count <= it.encoder_count;
        item_ch.now_ms        <= it.now_ms;
        item_ch.take_mask     <= it.take_mask;
        do @(posedge clk); while (!item_ch.ready);
        sent++;
    endtask

    task automatic sample_at(input logic level);
        item_t s;
        s.cmd           = CMD_SAMPLE;
        s.switch_level  = level;
        s.encoder_count = enc_pos;
        s.now_ms        = clock_ms;
        s.take_mask     = 8'($urandom);
        send_item(s);
        level_now = level;
    endtask

    task automatic take(input logic [7:0] mask, input logic level);
        item_t c;
        c.cmd           = CMD_CONSUME;
        c.switch_level  = level;
        c.encoder_count = 16'($urandom);
        c.now_ms        = ($urandom_range(0, 7) == 0) ? $urandom
                                                      : clock_ms + $urandom_range(0, 3);
        c.take_mask     = mask;
        send_item(c);
    endtask

    task automatic turn();
        int delta;
        if ($urandom_range(0, 7) == 0)
            enc_pos = 16'($urandom);
        else
        begin
            delta   = int'($urandom_range(0, 48)) - 24;
            enc_pos = enc_pos + 16'(delta);
        end
    endtask

    // hold lengths clustered one either side of each threshold or of a random mark
    function automatic logic [31:0] pick_hold();
        logic [31:0] mark;
        case ($urandom_range(0, 5))
            0:       mark = thr_now.click_timeout_ms;
            1:       mark = thr_now.long_press_ms;
            2, 3:    mark = thr_now.ultra_long_press_ms;
            4:       mark = thr_now.double_click_window_ms;
            default: mark = $urandom_range(0, 2 * thr_now.ultra_long_press_ms + 1);
        endcase
        return mark + $urandom_range(0, 2) - 1;
    endfunction

    task automatic press_cycle(input logic [31:0] hold, input bit twist);
        int unsigned n;
        logic [31:0] left;
        logic [31:0] step;
        n = twist ? $urandom_range(1, 3) : $urandom_range(0, 3);
        left = hold;
        sample_at(LEVEL_PRESSED);
        for (int i = 0; i < n; i++)
        begin
            step = $urandom_range(0, left);
            clock_ms += step;
            left -= step;
            if (twist && i == 0)
                turn();
            sample_at(LEVEL_PRESSED);
            if ($urandom_range(0, 3) == 0)
                take(8'($urandom), level_now);
        end
        clock_ms += left;
        sample_at(LEVEL_RELEASED);
    endtask

    task automatic play_gesture();
        logic [31:0] w;
        item_t       n;
        w = thr_now.double_click_window_ms;
        case ($urandom_range(0, 9))
            0, 1: press_cycle($urandom_range(0, thr_now.click_timeout_ms), 1'b0);
            2, 3:
            begin
                press_cycle($urandom_range(0, thr_now.click_timeout_ms), 1'b0);
                clock_ms += $urandom_range(0, w + 1);
                press_cycle($urandom_range(0, thr_now.click_timeout_ms), 1'b0);
            end
            4, 5: press_cycle(pick_hold(), 1'b0);
            6, 7: press_cycle(pick_hold(), 1'b1);
            8:
            begin
                n.cmd           = 1'($urandom);
                n.switch_level  = 1'($urandom);
                n.encoder_count = 16'($urandom);
                n.now_ms        = $urandom;
                n.take_mask     = 8'($urandom);
                send_item(n);
                if (n.cmd == CMD_SAMPLE)
                begin
                    level_now = n.switch_level;
                    enc_pos   = n.encoder_count;
                end
            end
            default: take(8'($urandom), 1'($urandom));
        endcase
        if ($urandom_range(0, 1) == 1)
            take(($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom), level_now);
        clock_ms += $urandom_range(0, 2 * w + 2);
        if ($urandom_range(0, 3) == 0)
            turn();
        sample_at(LEVEL_RELEASED);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_thresholds(input cfg_t t);
        drain();
        write_reg(REG_LONG_PRESS, t.long_press_ms);
        write_reg(REG_ULTRA_LONG, t.ultra_long_press_ms);
        write_reg(REG_CLICK_TMO, t.click_timeout_ms);
        write_reg(REG_DOUBLE_WIN, t.double_click_window_ms);
        cfg_ch.valid <= 1'b0;
        thr_now = t;
    endtask

    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial
    begin
        cfg_t plan [N_PHASES];
        item_ch.valid         <= 1'b0;
        item_ch.cmd           <= CMD_SAMPLE;
        item_ch.switch_level  <= LEVEL_RELEASED;
        item_ch.encoder_count <= '0;
        item_ch.now_ms        <= '0;
        item_ch.take_mask     <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_LONG_PRESS;
        cfg_ch.data           <= '0;
        thr_now = '{LONG_PRESS_RST, ULTRA_LONG_RST, CLICK_TMO_RST, DOUBLE_WIN_RST};

        plan[0] = thr_now;
        plan[1] = '{16'd40, 16'd120, 16'd25, 16'd30};
        plan[2] = '{16'd0, 16'd0, 16'd0, 16'd0};
        plan[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        plan[4] = '{16'd200, 16'd100, 16'd300, 16'd0};
        plan[5] = '{16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                    16'($urandom_range(0, 600)), 16'($urandom_range(0, 600))};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty consume, then a press held since reset with no edge seen
        take(8'hFF, LEVEL_RELEASED);
        clock_ms = 32'd1234;
        take(8'h00, LEVEL_PRESSED);
        // counter extremes and rounding toward zero
        enc_pos = 16'sh7FFF;
        sample_at(LEVEL_RELEASED);
        take(8'h01, LEVEL_RELEASED);
        enc_pos = 16'sh8000;
        sample_at(LEVEL_RELEASED);
        take(8'h00, LEVEL_RELEASED);
        enc_pos = -16'sd5;
        sample_at(LEVEL_RELEASED);
        enc_pos = 16'sd3;
        sample_at(LEVEL_RELEASED);
        take(8'hFF, LEVEL_RELEASED);
        // press and rotate on the same sample
        clock_ms = 32'd10000;
        enc_pos  = 16'sd40;
        sample_at(LEVEL_PRESSED);
        take(8'h02, LEVEL_PRESSED);
        clock_ms += 50;
        sample_at(LEVEL_RELEASED);
        // click, double click, long, ultra-long, press-and-rotate
        press_cycle(32'd100, 1'b0);
        clock_ms += 400;
        sample_at(LEVEL_RELEASED);
        press_cycle(32'd80, 1'b0);
        clock_ms += 100;
        press_cycle(32'd80, 1'b0);
        press_cycle(32'd1500, 1'b0);
        press_cycle(32'd3500, 1'b0);
        take(8'h7F, LEVEL_RELEASED);
        press_cycle(32'd200, 1'b1);
        take(8'h80, LEVEL_RELEASED);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
                set_thresholds(plan[p]);
            steady = (p % 2 == 1);
            // time wrap around the top of the counter
            if (p == 2)
                clock_ms = 32'hFFFF_FF00;
            for (int k = 0; k < PHASE_ITEMS; )
            begin
                k -= sent;
                play_gesture();
                k += sent;
            end
        end

        drain();
        if (fail_count == 0)
            $display("** encoder_button_gesture_detector: PASSED **");
        else
            $display("** encoder_button_gesture_detector: FAILED **");
        $finish;
    end

    initial
    begin
        #TIMEOUT;
        $display("** encoder_button_gesture_detector: FAILED **");
        $finish;
    end

endmodule
